// ===== hdl/rqfb_pkg.sv =====
// Shared types and constants for the ring queue with front and back insert.
`default_nettype none
package rqfb_pkg;

  // Storage geometry
  localparam int DEPTH    = 16;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = 5;
  localparam int KIND_W   = 2;
  localparam int RESULT_W = CNT_W + 2 + ELEM_W + 1;

  // Operation codes carried on the input tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // Result word, first member in the highest bits so ok sits at bit 0
  typedef struct packed {
    logic [CNT_W-1:0]  fill_count;
    logic              is_full;
    logic              is_empty;
    logic [ELEM_W-1:0] item_out;
    logic              ok;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/ring_queue_front_back_insert.sv =====
// Top level of the ring queue with append, insert at head and remove.
//
// Usage:
//   Input stream: in_tuser carries the operation (append at tail, insert at
//   head, remove from head), in_tdata the entry data. Each accepted word
//   gives exactly one result word on the output stream with the status, the
//   removed data and the empty flag, full flag and count after the operation.
//   Append and insert give their result in the cycle after acceptance; for a
//   removal the entry is read from the memory into its read register first, and
//   then into the result register. Append and insert take one word per cycle
//   while the receiver takes each result; a removal holds off the next word
//   until the entry read is done. The result register lets the next word in
//   during the cycle the current result is taken. While the receiver stalls,
//   the result holds and input tready stays low.
//   cfg_wr_en writes the capacity (0 taken as 1, above 16 taken as 16) and
//   empties the queue; write it only while the queue is idle.
//   Reset (rst_n low, synchronous) empties the queue, sets capacity to 16 and
//   drops any pending result. Entry memory needs no clearing pass.
`default_nettype none
module ring_queue_front_back_insert
  import rqfb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input stream
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [ELEM_W-1:0]   in_tdata,   // [31:0] item_data
  input  wire logic [KIND_W-1:0]   in_tuser,   // [1:0] kind
  // Result stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [RESULT_W-1:0] out_tdata,  // [0] ok, [32:1] item_out,
                                               // [33] is_empty, [34] is_full,
                                               // [39:35] fill_count
  // Configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [CNT_W-1:0]    cfg_wr_data
);

  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ELEM_W-1:0] mem_rdata;
  result_t           result;

  // Clamp the capacity into 1..DEPTH
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (cfg_wr_data > CNT_W'(DEPTH)) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(DEPTH);
    end else begin
      cap_r <= cap_nxt;
    end
  end

  rqfb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap        (cap_r),
    .clear      (cfg_wr_en),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_data    (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  rqfb_ram #(
    .DATA_W (ELEM_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = result;

endmodule
`default_nettype wire

// ===== hdl/rqfb_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module rqfb_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/rqfb_ctrl.sv =====
// Queue controller: pointers, count, memory access and the result register.
`default_nettype none
module rqfb_ctrl
  import rqfb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CNT_W-1:0]  cap,
  input  wire logic              clear,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [ELEM_W-1:0] in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output result_t                out_result,
  output logic                   mem_we,
  output logic      [IDX_W-1:0]  mem_waddr,
  output logic      [ELEM_W-1:0] mem_wdata,
  output logic                   mem_re,
  output logic      [IDX_W-1:0]  mem_raddr,
  input  wire logic [ELEM_W-1:0] mem_rdata
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             valid_r, valid_nxt;
  result_t          res_r, res_nxt;

  logic             accept;
  logic             not_full;
  logic             not_empty;
  logic             rd_start;
  logic [CNT_W-1:0] tail_inc;
  logic [CNT_W-1:0] head_inc;
  logic [IDX_W-1:0] head_dec;

  // Take a word only when idle and the result register frees up
  assign in_ready  = (state_r == ST_IDLE) && (!valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign not_full  = cnt_r < cap;
  assign not_empty = cnt_r != '0;
  assign rd_start  = accept && (kind_t'(in_kind) == KIND_REMOVE) && not_empty;

  // Pointer steps with wrap at the configured capacity
  assign tail_inc = {1'b0, tail_r} + CNT_W'(1);
  assign head_inc = {1'b0, head_r} + CNT_W'(1);
  assign head_dec = (head_r == '0) ? IDX_W'(cap - CNT_W'(1)) : head_r - IDX_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (rd_start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Queue update, memory access and result
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    valid_nxt = valid_r;
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = in_data;
    mem_re    = 1'b0;
    mem_raddr = head_r;

    // Drop a result the receiver has taken
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end

    if (state_r == ST_READ) begin
      // Removed data arrives from memory in the cycle after the read
      res_nxt.item_out = mem_rdata;
      valid_nxt        = 1'b1;
    end else if (accept) begin
      res_nxt.ok       = 1'b0;
      res_nxt.item_out = '0;
      valid_nxt        = 1'b1;
      case (kind_t'(in_kind))
        KIND_APPEND: begin
          if (not_full) begin
            mem_we     = 1'b1;
            mem_waddr  = tail_r;
            tail_nxt   = (tail_inc >= cap) ? '0 : tail_inc[IDX_W-1:0];
            cnt_nxt    = cnt_r + CNT_W'(1);
            res_nxt.ok = 1'b1;
          end
        end
        KIND_INSERT: begin
          if (not_full) begin
            mem_we     = 1'b1;
            mem_waddr  = head_dec;
            head_nxt   = head_dec;
            cnt_nxt    = cnt_r + CNT_W'(1);
            res_nxt.ok = 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (not_empty) begin
            mem_re     = 1'b1;
            mem_raddr  = head_r;
            head_nxt   = (head_inc >= cap) ? '0 : head_inc[IDX_W-1:0];
            cnt_nxt    = cnt_r - CNT_W'(1);
            res_nxt.ok = 1'b1;
            // Hold the word back until the read data is in
            valid_nxt  = 1'b0;
          end
        end
        default: begin
        end
      endcase
      res_nxt.fill_count = cnt_nxt;
      res_nxt.is_empty   = (cnt_nxt == '0);
      res_nxt.is_full    = (cnt_nxt == cap);
    end

    // Capacity change empties the queue
    if (clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule
`default_nettype wire

// ===== tb/ring_queue_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ring queue: tracks the queue from accepted words and compares each result.
module ring_queue_checker
  import rqfb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [ELEM_W-1:0]   in_tdata,
  input  logic [KIND_W-1:0]   in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [RESULT_W-1:0] out_tdata,
  input  logic                cfg_wr_en,
  input  logic [CNT_W-1:0]    cfg_wr_data,
  output int                  mismatches,
  output int                  results_seen
);

  // Shadow copy of the queue
  logic [ELEM_W-1:0] slots [DEPTH];
  logic [CNT_W-1:0]  head_ptr;
  logic [CNT_W-1:0]  tail_ptr;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  cap;

  // Results still owed by the block, oldest first
  result_t expected_results [$];

  // Apply one operation to the shadow queue and return the result it gives
  function automatic result_t apply_op(input logic [KIND_W-1:0] kind,
                                       input logic [ELEM_W-1:0] data);
    result_t r;
    r = '0;
    case (kind)
      KIND_APPEND: begin
        if (held < cap) begin
          slots[tail_ptr[IDX_W-1:0]] = data;
          tail_ptr = (tail_ptr + 5'd1 >= cap) ? '0 : tail_ptr + 5'd1;
          held++;
          r.ok = 1'b1;
        end
      end
      KIND_INSERT: begin
        // step the head back, wrapping below zero to the last slot of the configured capacity
        if (held < cap) begin
          head_ptr = (head_ptr == '0) ? cap - 5'd1 : head_ptr - 5'd1;
          slots[head_ptr[IDX_W-1:0]] = data;
          held++;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (held != '0) begin
          r.item_out = slots[head_ptr[IDX_W-1:0]];
          head_ptr = (head_ptr + 5'd1 >= cap) ? '0 : head_ptr + 5'd1;
          held--;
          r.ok = 1'b1;
        end
      end
      default: ;  // unknown operation leaves the queue alone
    endcase
    r.is_empty   = (held == '0);
    r.is_full    = (held == cap);
    r.fill_count = held;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      // clear everything the block clears on reset
      head_ptr = '0;
      tail_ptr = '0;
      held     = '0;
      cap      = CNT_W'(DEPTH);
      expected_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      // a capacity write clamps the value and empties the queue
      if (cfg_wr_en) begin
        if (cfg_wr_data == '0)
          cap = 5'd1;
        else if (cfg_wr_data > DEPTH)
          cap = CNT_W'(DEPTH);
        else
          cap = cfg_wr_data;
        head_ptr = '0;
        tail_ptr = '0;
        held     = '0;
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_op(in_tuser, in_tdata));
      // compare each result word with the oldest prediction
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: 0x%0h", out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("ok", 64'(want.ok), 64'(got.ok));
          check_field("item_out", 64'(want.item_out), 64'(got.item_out));
          check_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
          check_field("is_full", 64'(want.is_full), 64'(got.is_full));
          check_field("fill_count", 64'(want.fill_count), 64'(got.fill_count));
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top: drives directed and random queue operations and reports the verdict.
module testbench;
  import rqfb_pkg::*;

  // tuser code that names no operation
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
  localparam int PHASE_WORDS = 50;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic [ELEM_W-1:0]   in_tdata    = '0;
  logic [KIND_W-1:0]   in_tuser    = '0;
  logic                out_tready  = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]    cfg_wr_data = '0;
  wire                 in_tready;
  wire                 out_tvalid;
  wire  [RESULT_W-1:0] out_tdata;

  int mismatches;
  int results_seen;
  int words_sent = 0;
  bit no_idle    = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ring_queue_front_back_insert dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ring_queue_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .results_seen (results_seen)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [ELEM_W-1:0] data);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Stop sending and wait until every result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen != words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Alternate fill-leaning and drain-leaning stretches so full and empty are both hit
  task automatic random_phase(input logic [CNT_W-1:0] cap_code);
    int                eff;
    int                span;
    int                r;
    bit                fill_lean;
    logic [KIND_W-1:0] kind;
    logic [ELEM_W-1:0] data;
    eff = (cap_code == '0) ? 1 : ((cap_code > DEPTH) ? DEPTH : int'(cap_code));
    span = eff + 8;
    fill_lean = 1'b0;
    drain();
    write_capacity(cap_code);
    for (int n = 0; n < PHASE_WORDS; n++) begin
      if (n % 25 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      if (n % span == 0)
        fill_lean = !fill_lean;
      r = $urandom_range(0, 99);
      if (r < 3)
        kind = KIND_UNKNOWN;
      else if ((r < 88) == fill_lean)
        kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
      else
        kind = KIND_REMOVE;
      case ($urandom_range(0, 9))
        0:       data = '0;
        1:       data = '1;
        default: data = $urandom;
      endcase
      send_word(kind, data);
    end
  endtask

  // Take result words with random stalls
  initial begin : receiver
    int gap;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] cap_codes [9];
    cap_codes = '{5'd31, 5'd2, 5'd16, 5'd0, 5'd17, 5'd1, 5'd7, 5'd0, 5'd0};
    cap_codes[7] = CNT_W'($urandom_range(0, 31));
    cap_codes[8] = CNT_W'($urandom_range(3, 15));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Full capacity after reset: empty removal, unknown op, both inserts, head wrap
    send_word(KIND_REMOVE, 32'h0000_0000);
    send_word(KIND_UNKNOWN, 32'hFFFF_FFFF);
    send_word(KIND_APPEND, 32'h0000_0000);
    send_word(KIND_APPEND, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'hA5A5_A5A5);
    send_word(KIND_INSERT, 32'h5A5A_5A5A);
    send_word(KIND_UNKNOWN, 32'h1234_5678);
    send_word(KIND_REMOVE, 32'hFFFF_FFFF);
    send_word(KIND_REMOVE, 32'h0000_0000);
    send_word(KIND_REMOVE, 32'h0000_0000);
    send_word(KIND_REMOVE, 32'h0000_0000);
    send_word(KIND_REMOVE, 32'h0000_0000);

    // Zero capacity taken as one: full on every insert after the first
    drain();
    write_capacity(5'd0);
    send_word(KIND_APPEND, 32'h0000_1234);
    send_word(KIND_APPEND, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'h8000_0001);
    send_word(KIND_REMOVE, 32'h0000_0000);
    send_word(KIND_INSERT, 32'hDEAD_BEEF);
    send_word(KIND_INSERT, 32'h0000_0000);
    send_word(KIND_REMOVE, 32'h0000_0000);
    send_word(KIND_REMOVE, 32'h0000_0000);

    foreach (cap_codes[i])
      random_phase(cap_codes[i]);

    drain();
    if (mismatches == 0 && results_seen == words_sent)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Hard stop well past the slowest passing run
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
